/* rtl/wsv_pkg.sv */
// Package for windowed_sample_variance: field widths, reset constants
// and the back-end state type. No dependencies.
`default_nettype none
package wsv_pkg;
    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 13;
    localparam int OUT_W          = 40;
    localparam int FRAC_W         = 8;
    localparam int MAX_WINDOW_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUB,
        S_DIV,
        S_OUT
    } t_bstate;
endpackage
`default_nettype wire

/* rtl/wsv_front.sv */
// Front end: window length register, per-window count, sum and sum of squares.
// Pushes one closed window per item into the queue. Uses wsv_pkg.
`default_nettype none
module wsv_front #(
    parameter int MAX_WINDOW = wsv_pkg::MAX_WINDOW_DEF,
    parameter int W_CNT      = $clog2(MAX_WINDOW + 1),
    parameter int W_SUM      = wsv_pkg::SAMPLE_W + $clog2(MAX_WINDOW),
    parameter int W_SQ       = 2 * wsv_pkg::SAMPLE_W - 1 + $clog2(MAX_WINDOW),
    parameter int W_ENT      = W_CNT + W_SUM + W_SQ
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [wsv_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                i_valid,
    input  wire logic signed [wsv_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                                i_full,
    output logic                                     o_push,
    output logic [W_ENT-1:0]                         o_push_data
);
    import wsv_pkg::*;

    localparam int W_LEN = (W_CNT > CFG_W) ? W_CNT : CFG_W;

    logic [CFG_W-1:0]        r_len;
    logic [W_CNT-1:0]        r_cnt, n_cnt;
    logic signed [W_SUM-1:0] r_sum, n_sum;
    logic [W_SQ-1:0]         r_sq, n_sq;
    logic [W_LEN-1:0]        eff;
    logic [SAMPLE_W-1:0]     ax;
    logic [2*SAMPLE_W-1:0]   ax_sq;
    logic                    accept, close;

    always_comb begin
        eff = W_LEN'(r_len);
        if (eff < W_LEN'(2)) begin
            eff = W_LEN'(2);
        end
        if (eff > W_LEN'(MAX_WINDOW)) begin
            eff = W_LEN'(MAX_WINDOW);
        end
    end

    always_comb begin
        ax     = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
        ax_sq  = ax * ax;
        n_cnt  = r_cnt + W_CNT'(1);
        n_sum  = r_sum + {{(W_SUM-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        n_sq   = r_sq + W_SQ'(ax_sq);
        close  = W_LEN'(n_cnt) >= eff;
        accept = i_valid && !i_full;
        o_push = accept && close;
        o_push_data = {n_cnt, n_sum, n_sq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CFG_RESET;
            r_cnt <= '0;
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (accept) begin
                if (close) begin
                    r_cnt <= '0;
                    r_sum <= '0;
                    r_sq  <= '0;
                end else begin
                    r_cnt <= n_cnt;
                    r_sum <= n_sum;
                    r_sq  <= n_sq;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/wsv_fifo.sv */
// Short queue of closed windows between front and back end.
// Show-ahead read. Uses wsv_pkg for the default depth.
`default_nettype none
module wsv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wsv_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import wsv_pkg::*;

    localparam int W_PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_FCNT = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [W_PTR-1:0]  r_wp, r_rp;
    logic [W_FCNT-1:0] r_count;

    assign o_full  = r_count == W_FCNT'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == W_PTR'(DEPTH - 1)) ? '0 : r_wp + W_PTR'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == W_PTR'(DEPTH - 1)) ? '0 : r_rp + W_PTR'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + W_FCNT'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - W_FCNT'(1);
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/wsv_back.sv */
// Back end: numerator and denominator products, restoring divider for the
// Q.8 quotient, saturation and output register. Uses wsv_pkg.
`default_nettype none
module wsv_back #(
    parameter int W_CNT = 13,
    parameter int W_SUM = 28,
    parameter int W_SQ  = 43,
    parameter int W_ENT = W_CNT + W_SUM + W_SQ
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_empty,
    input  wire logic [W_ENT-1:0]           i_data,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [wsv_pkg::OUT_W-1:0]       o_variance_q8
);
    import wsv_pkg::*;

    localparam int W_PROD = W_SQ + W_CNT;
    localparam int W_SQM  = 2 * W_SUM;
    localparam int W_NUM  = (W_PROD > W_SQM) ? W_PROD : W_SQM;
    localparam int W_DEN  = 2 * W_CNT;
    localparam int W_DIVD = W_PROD + FRAC_W;
    localparam int W_DC   = $clog2(W_DIVD + 1);

    t_bstate r_state, n_state;

    logic [W_CNT-1:0]        r_n;
    logic signed [W_SUM-1:0] r_sum;
    logic [W_SQ-1:0]         r_sumsq;
    logic [W_PROD-1:0]       r_prod;
    logic [W_SQM-1:0]        r_sqm;
    logic [W_DEN-1:0]        r_den, r_rem;
    logic [W_DIVD-1:0]       r_quo;
    logic [W_DC-1:0]         r_dcnt;
    logic [W_SUM-1:0]        mag;
    logic [W_NUM-1:0]        num;
    logic [W_DEN:0]          trial;
    logic                    ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUB;
            S_SUB:  n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == W_DC'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mag   = r_sum[W_SUM-1] ? W_SUM'(-r_sum) : W_SUM'(r_sum);
        num   = (W_NUM'(r_prod) >= W_NUM'(r_sqm)) ? W_NUM'(r_prod) - W_NUM'(r_sqm) : '0;
        trial = {r_rem, r_quo[W_DIVD-1]};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                {r_n, r_sum, r_sumsq} <= i_data;
            end
            S_MUL1: begin
                r_prod <= W_PROD'(r_n) * W_PROD'(r_sumsq);
                r_den  <= W_DEN'(r_n) * W_DEN'(r_n - W_CNT'(1));
            end
            S_MUL2: begin
                r_sqm <= W_SQM'(mag) * W_SQM'(mag);
            end
            S_SUB: begin
                r_quo  <= {W_PROD'(num), {FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_dcnt <= W_DC'(W_DIVD);
            end
            S_DIV: begin
                r_quo  <= {r_quo[W_DIVD-2:0], ge};
                r_rem  <= ge ? W_DEN'(trial - {1'b0, r_den}) : trial[W_DEN-1:0];
                r_dcnt <= r_dcnt - W_DC'(1);
            end
            default: ;
        endcase
    end

    assign o_variance_q8 = (|r_quo[W_DIVD-1:OUT_W]) ? {OUT_W{1'b1}} : r_quo[OUT_W-1:0];
endmodule
`default_nettype wire

/* rtl/windowed_sample_variance.sv */
// windowed_sample_variance top level: front accumulator, window queue, divider back end.
// Front takes one sample per cycle while the queue is not full; the back end works on one window at a time
// (three product/subtract steps, then the divider with one quotient bit per cycle).
// Result is valid once the window has left the queue and passed those steps, plus queue wait and stalls.
// Windows shorter than the back end's work per window fill the two-entry queue and stall the input.
// Synchronous active-low reset clears accumulators, queue and back end; length = 1000.
`default_nettype none
module windowed_sample_variance #(
    parameter int MAX_WINDOW = wsv_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [wsv_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [wsv_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [wsv_pkg::OUT_W-1:0]                o_variance_q8
);
    import wsv_pkg::*;

    localparam int W_CNT = $clog2(MAX_WINDOW + 1);
    localparam int W_SUM = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int W_SQ  = 2 * SAMPLE_W - 1 + $clog2(MAX_WINDOW);
    localparam int W_ENT = W_CNT + W_SUM + W_SQ;

    logic             push, pop, full, empty;
    logic [W_ENT-1:0] push_data, pop_data;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;

    wsv_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .W_CNT      (W_CNT),
        .W_SUM      (W_SUM),
        .W_SQ       (W_SQ),
        .W_ENT      (W_ENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    wsv_fifo #(
        .WIDTH (W_ENT),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    wsv_back #(
        .W_CNT (W_CNT),
        .W_SUM (W_SUM),
        .W_SQ  (W_SQ),
        .W_ENT (W_ENT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_data        (pop_data),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_variance_q8 (o_variance_q8)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("window pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty))
        else $error("window popped from empty queue");

    a_pop_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !o_valid ##1 !o_valid)
        else $error("back end took a window while a result was pending");
endmodule
`default_nettype wire

/* tb/sv/tb_windowed_sample_variance.sv */
// Self-checking testbench for windowed_sample_variance: directed and random samples
// across many window lengths, predicted by an in-line window accumulator.
// Depends on wsv_pkg and the windowed_sample_variance RTL.
module tb_windowed_sample_variance;
    timeunit 1ns;
    timeprecision 1ps;
    import wsv_pkg::*;

    localparam longint unsigned OUT_LIMIT = (64'd1 << OUT_W) - 1;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1550;
    localparam int LONG_HOLD    = 400;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [OUT_W-1:0]           o_variance_q8;

    // window accumulator model
    logic [CFG_W-1:0]           window_length_reg;
    logic [CFG_W-1:0]           window_count;
    logic signed [27:0]         window_sum;
    logic [42:0]                window_sum_sq;

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    logic [OUT_W-1:0]           expected_variance[$];

    int send_gap_max = 0;
    int stall_max = 0;
    int long_hold_cycles = 0;
    bit failed = 1'b0;

    windowed_sample_variance uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_variance_q8 (o_variance_q8)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        logic [CFG_W-1:0] eff;
        longint sx, ls;
        longint unsigned sq_in, n, mag, prod, sq, num, den, q, r, v;
        sx = longint'(s);
        sq_in = sx * sx;
        window_count  = window_count + 1'b1;
        window_sum    = window_sum + 28'(sx);
        window_sum_sq = window_sum_sq + 43'(sq_in);
        eff = window_length_reg;
        if (eff < 2) begin
            eff = CFG_W'(2);
        end else if (eff > MAX_WINDOW_DEF) begin
            eff = CFG_W'(MAX_WINDOW_DEF);
        end
        if (window_count >= eff) begin
            n    = 64'(window_count);
            ls   = longint'(window_sum);
            mag  = (ls < 0) ? -ls : ls;
            prod = n * window_sum_sq;
            sq   = mag * mag;
            num  = (prod >= sq) ? prod - sq : 0;
            den  = n * (n - 1);
            q    = num / den;
            r    = num % den;
            if (q > (OUT_LIMIT >> FRAC_W)) begin
                v = OUT_LIMIT;
            end else begin
                v = (q << FRAC_W) + (r << FRAC_W) / den;
                if (v > OUT_LIMIT) v = OUT_LIMIT;
            end
            expected_variance.push_back(v[OUT_W-1:0]);
            window_count  = '0;
            window_sum    = '0;
            window_sum_sq = '0;
        end
    endtask

    // sender: bursts of random length, random gaps
    always @(posedge i_clk) begin : sender
        int burst_left;
        int gap_left;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) take_sample(i_sample);
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_sample <= pending_samples.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: alternating stall/go runs, plus an occasional long hold
    always @(posedge i_clk) begin : receiver
        int run_left;
        int hold_left;
        bit stalling;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            run_left = 0;
            hold_left = 0;
            stalling = 1'b0;
        end else begin
            if (long_hold_cycles > 0) begin
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = (stall_max > 0) ? !stalling : 1'b0;
                    run_left = stalling ? $urandom_range(1, stall_max) : $urandom_range(1, 12);
                end
                run_left = run_left - 1;
                i_stall <= stalling;
            end
        end
    end

    always @(posedge i_clk) begin : result_mon
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_variance.size() == 0) begin
                $error("unexpected item: variance_q8 actual %0d", o_variance_q8);
                failed = 1'b1;
            end else begin
                want = expected_variance.pop_front();
                if (o_variance_q8 !== want) begin
                    $error("variance_q8 mismatch: expected %0d, actual %0d", want, o_variance_q8);
                    failed = 1'b1;
                end
            end
        end
    end

    // wait until every item is taken and every result is back, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || i_valid || expected_variance.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        drain();
        i_cfg_data <= len;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_length_reg = len;
    endtask

    initial begin : stimulus
        int random_items;
        int n_items;
        int sel;
        bit first;
        logic [CFG_W-1:0] len;
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [SAMPLE_W-1:0] base;

        window_length_reg = CFG_RESET;
        window_count = '0;
        window_sum = '0;
        window_sum_sq = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pairs at the extremes
        write_length(2);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'shffff);
        pending_samples.push_back(16'sh0001);
        write_length(3);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        // length shortened mid-window: closes with the actual count
        write_length(5);
        pending_samples.push_back(16'sh1234);
        pending_samples.push_back(16'shedcb);
        pending_samples.push_back(16'sh7fff);
        write_length(2);
        pending_samples.push_back(16'sh8001);
        // lengths below range act as two
        write_length(0);
        pending_samples.push_back(16'sh0005);
        pending_samples.push_back(16'shfffb);
        write_length(1);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh7fff);
        // lengths above range act as the maximum
        write_length(13'h1fff);
        repeat (5) pending_samples.push_back(16'sh8000);
        write_length(CFG_W'(MAX_WINDOW_DEF));
        pending_samples.push_back(16'sh7fff);
        write_length(2);
        pending_samples.push_back(16'sh7fff);

        random_items = 0;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (first) len = 2;
            else if (sel < 13) len = CFG_W'($urandom_range(2, 24));
            else if (sel < 15) len = CFG_W'($urandom_range(25, 300));
            else if (sel == 15) len = CFG_W'($urandom_range(0, 1));
            else if (sel == 16) len = CFG_W'($urandom_range(MAX_WINDOW_DEF, 8191));
            else len = CFG_W'($urandom_range(301, MAX_WINDOW_DEF));
            write_length(len);
            case ($urandom_range(0, 2))
                0: send_gap_max = 0;
                1: send_gap_max = 3;
                default: send_gap_max = 12;
            endcase
            case ($urandom_range(0, 2))
                0: stall_max = 0;
                1: stall_max = 4;
                default: stall_max = 25;
            endcase
            if (first) begin
                // short windows at full rate against a long output hold: input must back up
                send_gap_max = 0;
                stall_max = 0;
                n_items = 300;
                @(negedge i_clk);
                long_hold_cycles = LONG_HOLD;
            end else begin
                n_items = $urandom_range(1, 60);
            end
            base = 16'($urandom);
            for (int i = 0; i < n_items; i++) begin
                sel = $urandom_range(0, 19);
                if (sel < 12) begin
                    smp = 16'($urandom);
                end else if (sel < 15) begin
                    case ($urandom_range(0, 4))
                        0: smp = 16'sh7fff;
                        1: smp = 16'sh8000;
                        2: smp = 16'sh0000;
                        3: smp = 16'shffff;
                        default: smp = 16'sh0001;
                    endcase
                end else begin
                    smp = base + $signed(16'($urandom_range(0, 63))) - 16'sd32;
                end
                pending_samples.push_back(smp);
            end
            random_items += n_items;
            first = 1'b0;
        end

        drain();
        if (failed) begin
            $display("tb_windowed_sample_variance failed");
        end else begin
            $display("tb_windowed_sample_variance passed");
        end
        $finish;
    end

    initial begin : watchdog
        #9_600_000;
        $display("tb_windowed_sample_variance failed");
        $finish;
    end
endmodule
